// ----- rtl/gbn_pkg.sv -----
`timescale 1ns / 1ps

package gbn_pkg;

    // Window and sequence space
    localparam int WINDOW_SIZE = 32;
    localparam int SLOT_W      = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int SEQ_W       = 31;
    localparam int CHK_W       = 32;
    localparam int TIMER_W     = 16;

    // Payload layout
    localparam int PAY_BYTES = 20;
    localparam int LOW_W     = 64;
    localparam int MID_W     = 64;
    localparam int HIGH_W    = 32;
    localparam int PAY_W     = LOW_W + MID_W + HIGH_W;
    localparam int SUM_W     = 13;  // signed sum of up to twenty signed bytes
    localparam int GROUPS    = 4;
    localparam int GROUP_LEN = PAY_BYTES / GROUPS;

    // Stream words
    localparam int ACT_W     = 2;
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 224;

    // Front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ACT_W-1:0]   ACT_MSG  = 2'd0;
    localparam logic [ACT_W-1:0]   ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0]   ACT_TICK = 2'd2;

    localparam logic               KIND_SENT    = 1'b0;
    localparam logic               KIND_REFUSED = 1'b1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd20;
    localparam logic [CHK_W-1:0]   ACK_GOOD      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CLS_MSG  = 2'd0,
        CLS_ACK  = 2'd1,
        CLS_TICK = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic [PAY_W-1:0]   payload;    // bytes from the first zero byte on cleared
        logic [SUM_W-1:0]   byte_sum;   // two's complement
        logic [SEQ_W-1:0]   ack_number;
    } item_t;

endpackage

// ----- rtl/go_back_n_sender_top.sv -----
// Go-Back-N sender.
// Input words (s_t*): s_tuser carries the action (message, acknowledgement,
// timer tick); s_tdata carries the payload and the acknowledgement fields.
// Output words (m_t*): one per sent or refused packet; m_tuser is the kind,
// m_tlast marks the final word of the run caused by one input word.
// Configuration (cfg_*): one write channel for the timeout in ticks; write it
// only while the block is quiet. cfg_ready is always high.
// A message result is presented on m_t* at the edge at which it leaves the
// two-word input queue. Throughput: one input word per cycle while the queue
// has room; acknowledgements and ticks make no output word. A timeout replays
// the n outstanding packets from the packet store as n output words (one
// registered read per word); meanwhile the queue fills and then holds
// s_tready low.
// Reset: window base and next sequence go to 1, the timer stops, timeout
// returns to 20. The packet store needs no clearing pass.
// Receiver stall: the output register holds its word; a waiting message
// stays in the queue while acknowledgements and ticks ahead of it proceed.
`timescale 1ns / 1ps

module go_back_n_sender_top import gbn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: payload_low, payload_mid, payload_high,
    // ack_number, ack_checksum, one zero pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: action
    input  logic [ACT_W-1:0]     s_tuser,
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: seq_number, packet_checksum, out_payload_low,
    // out_payload_mid, out_payload_high, one zero pad bit
    output logic [M_TDATA_W-1:0] m_tdata,
    // tuser: kind
    output logic                 m_tuser,
    output logic                 m_tlast,
    // Configuration: timeout_ticks
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMER_W-1:0]   cfg_data
);

    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // Classify and strip payload, drop bad acknowledgements
    gbn_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    // Decouple front and back
    gbn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (q_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // Window state, timer, packet store and output register
    gbn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/gbn_front.sv -----
`timescale 1ns / 1ps

module gbn_front import gbn_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]     s_tuser,
    input  logic                 q_ready,
    output logic                 push,
    output item_t                push_item
);

    logic [PAY_W-1:0]  raw_pay;
    logic [PAY_BYTES-1:0] nonzero;
    logic [PAY_BYTES-1:0] keep;
    logic [SUM_W-1:0]  byte_val [PAY_BYTES];
    logic [SUM_W-1:0]  group_sum [GROUPS];
    logic [SUM_W-1:0]  total;
    logic [SEQ_W-1:0]  ack_number;
    logic [CHK_W-1:0]  ack_checksum;
    logic              ack_ok;
    logic              take;

    assign raw_pay      = s_tdata[PAY_W-1:0];
    assign ack_number   = s_tdata[PAY_W +: SEQ_W];
    assign ack_checksum = s_tdata[PAY_W+SEQ_W +: CHK_W];
    assign ack_ok       = (CHK_W'(ack_number) + ack_checksum) == ACK_GOOD;

    // Keep a byte only while no zero byte precedes or equals it
    always_comb begin
        logic [PAY_BYTES-1:0] upto;
        for (int i = 0; i < PAY_BYTES; i++) begin
            nonzero[i] = raw_pay[8*i +: 8] != 8'd0;
        end
        for (int i = 0; i < PAY_BYTES; i++) begin
            upto    = PAY_BYTES'((64'd1 << (i + 1)) - 64'd1);
            keep[i] = &(nonzero | ~upto);
        end
        for (int i = 0; i < PAY_BYTES; i++) begin
            byte_val[i] = keep[i] ?
                {{(SUM_W-8){raw_pay[8*i+7]}}, raw_pay[8*i +: 8]} : SUM_W'(0);
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            group_sum[g] = SUM_W'(0);
            for (int k = 0; k < GROUP_LEN; k++) begin
                group_sum[g] = group_sum[g] + byte_val[g*GROUP_LEN + k];
            end
        end
        total = (group_sum[0] + group_sum[1]) + (group_sum[2] + group_sum[3]);
    end

    always_comb begin
        push_item.payload    = '0;
        push_item.byte_sum   = total;
        push_item.ack_number = ack_number;
        push_item.cls        = CLS_MSG;
        for (int i = 0; i < PAY_BYTES; i++) begin
            push_item.payload[8*i +: 8] = keep[i] ? raw_pay[8*i +: 8] : 8'd0;
        end
        // Drop bad acknowledgements and unused codes here
        case (s_tuser)
            ACT_MSG: begin
                push_item.cls = CLS_MSG;
                take          = 1'b1;
            end
            ACT_ACK: begin
                push_item.cls = CLS_ACK;
                take          = ack_ok;
            end
            ACT_TICK: begin
                push_item.cls = CLS_TICK;
                take          = 1'b1;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    assign s_tready = q_ready;
    assign push     = s_tvalid & q_ready & take;

endmodule

// ----- rtl/gbn_queue.sv -----
`timescale 1ns / 1ps

module gbn_queue import gbn_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_pop,
    output item_t out_item
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign in_ready  = fill_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid & in_ready;
    assign do_pop    = out_pop & out_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/gbn_back.sv -----
`timescale 1ns / 1ps

module gbn_back import gbn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  item_t                q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    typedef enum logic [1:0] {
        ST_SERVE  = 2'b01,
        ST_RESEND = 2'b10
    } state_t;

    typedef struct packed {
        logic [CHK_W-1:0] checksum;
        logic [PAY_W-1:0] payload;
    } slot_t;

    state_t             state_reg, state_next;
    logic [TIMER_W-1:0] timeout_reg;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [SEQ_W-1:0]   next_reg, next_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic               timer_on_reg, timer_on_next;
    logic [TIMER_W-1:0] timer_left_reg, timer_left_next;
    logic [SLOT_W-1:0]  burst_slot_reg, burst_slot_next;
    logic [SEQ_W-1:0]   burst_seq_reg, burst_seq_next;
    logic [CNT_W-1:0]   burst_left_reg, burst_left_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic               m_last_reg, m_last_next;
    logic [SEQ_W-1:0]   m_seq_reg, m_seq_next;
    logic [CHK_W-1:0]   m_chk_reg, m_chk_next;
    logic [PAY_W-1:0]   m_pay_reg, m_pay_next;
    logic               out_load;
    logic               out_free;

    slot_t              store_mem [WINDOW_SIZE];
    slot_t              rd_data_reg;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    slot_t              wr_data;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_slot;

    logic [TIMER_W-1:0] timer_load;
    logic [CHK_W-1:0]   msg_chk;
    logic [SEQ_W-1:0]   ack_dist;

    assign cfg_ready  = 1'b1;
    assign out_free   = ~m_valid_reg | m_tready;
    assign timer_load = (timeout_reg == '0) ? TIMER_W'(1) : timeout_reg;
    assign msg_chk    = ~({{(CHK_W-SUM_W){q_item.byte_sum[SUM_W-1]}}, q_item.byte_sum}
                          + CHK_W'(next_reg));
    assign ack_dist   = q_item.ack_number - base_reg + SEQ_W'(1);

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        next_next       = next_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        timer_on_next   = timer_on_reg;
        timer_left_next = timer_left_reg;
        burst_slot_next = burst_slot_reg;
        burst_seq_next  = burst_seq_reg;
        burst_left_next = burst_left_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        m_seq_next      = m_seq_reg;
        m_chk_next      = m_chk_reg;
        m_pay_next      = m_pay_reg;
        out_load        = 1'b0;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_slot         = SLOT_W'(head_reg + count_reg[SLOT_W-1:0]);
        wr_data         = '{checksum: msg_chk, payload: q_item.payload};
        rd_en           = 1'b0;
        rd_slot         = head_reg;

        case (state_reg)
            ST_SERVE: begin
                if (q_valid) begin
                    case (q_item.cls)
                        CLS_MSG: begin
                            if (out_free) begin
                                q_pop       = 1'b1;
                                out_load    = 1'b1;
                                m_last_next = 1'b1;
                                if (count_reg >= CNT_W'(WINDOW_SIZE)) begin
                                    // Window full: refuse with zeroed fields
                                    m_kind_next = KIND_REFUSED;
                                    m_seq_next  = '0;
                                    m_chk_next  = '0;
                                    m_pay_next  = '0;
                                end else begin
                                    m_kind_next = KIND_SENT;
                                    m_seq_next  = next_reg;
                                    m_chk_next  = msg_chk;
                                    m_pay_next  = q_item.payload;
                                    wr_en       = 1'b1;
                                    next_next   = next_reg + SEQ_W'(1);
                                    count_next  = count_reg + CNT_W'(1);
                                    if (count_reg == '0) begin
                                        timer_on_next   = 1'b1;
                                        timer_left_next = timer_load;
                                    end
                                end
                            end
                        end
                        CLS_ACK: begin
                            q_pop = 1'b1;
                            if (ack_dist <= SEQ_W'(count_reg)) begin
                                head_next  = SLOT_W'(head_reg + ack_dist[SLOT_W-1:0]);
                                count_next = count_reg - ack_dist[CNT_W-1:0];
                                base_next  = q_item.ack_number + SEQ_W'(1);
                                if (count_next == '0) begin
                                    timer_on_next   = 1'b0;
                                    timer_left_next = '0;
                                end else begin
                                    timer_on_next   = 1'b1;
                                    timer_left_next = timer_load;
                                end
                            end
                        end
                        CLS_TICK: begin
                            q_pop = 1'b1;
                            if (timer_on_reg) begin
                                if (timer_left_reg > TIMER_W'(1)) begin
                                    timer_left_next = timer_left_reg - TIMER_W'(1);
                                end else if (count_reg == '0) begin
                                    timer_on_next   = 1'b0;
                                    timer_left_next = '0;
                                end else begin
                                    // Expiry: restart and replay the window
                                    timer_left_next = timer_load;
                                    rd_en           = 1'b1;
                                    burst_slot_next = head_reg + SLOT_W'(1);
                                    burst_seq_next  = base_reg;
                                    burst_left_next = count_reg;
                                    state_next      = ST_RESEND;
                                end
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RESEND: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    m_kind_next     = KIND_SENT;
                    m_seq_next      = burst_seq_reg;
                    m_chk_next      = rd_data_reg.checksum;
                    m_pay_next      = rd_data_reg.payload;
                    m_last_next     = burst_left_reg == CNT_W'(1);
                    burst_seq_next  = burst_seq_reg + SEQ_W'(1);
                    burst_left_next = burst_left_reg - CNT_W'(1);
                    if (burst_left_reg != CNT_W'(1)) begin
                        rd_en           = 1'b1;
                        rd_slot         = burst_slot_reg;
                        burst_slot_next = burst_slot_reg + SLOT_W'(1);
                    end else begin
                        state_next = ST_SERVE;
                    end
                end
            end
            default: begin
                state_next = ST_SERVE;
            end
        endcase

        m_valid_next = out_load | (m_valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SERVE;
            timeout_reg    <= TIMEOUT_RESET;
            base_reg       <= SEQ_W'(1);
            next_reg       <= SEQ_W'(1);
            count_reg      <= '0;
            head_reg       <= '0;
            timer_on_reg   <= 1'b0;
            timer_left_reg <= '0;
            burst_slot_reg <= '0;
            burst_seq_reg  <= '0;
            burst_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            base_reg       <= base_next;
            next_reg       <= next_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            timer_on_reg   <= timer_on_next;
            timer_left_reg <= timer_left_next;
            burst_slot_reg <= burst_slot_next;
            burst_seq_reg  <= burst_seq_next;
            burst_left_reg <= burst_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
        m_seq_reg  <= m_seq_next;
        m_chk_reg  <= m_chk_next;
        m_pay_reg  <= m_pay_next;
    end

    // Packet store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_slot] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_slot];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_pay_reg, m_chk_reg, m_seq_reg};

`ifndef SYNTHESIS
    a_count_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_reg - base_reg) == SEQ_W'(count_reg))
        else $error("outstanding count disagrees with window edges");

    a_timer_tracks_window: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_on_reg == (count_reg != '0))
        else $error("timer state disagrees with outstanding count");

    a_timer_left: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_on_reg |-> (timer_left_reg != '0))
        else $error("running timer holds zero ticks");

    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESEND) |-> (burst_left_reg != '0 && burst_left_reg <= count_reg))
        else $error("resend run exceeds the window");

    a_burst_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESEND) |-> !q_pop)
        else $error("queue popped during resend");
`endif

endmodule
